// ===== hw/rtl/sapsearch_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sapsearch_pkg;
    localparam int AddrW = 16;
    localparam int PatW  = 8;
    localparam int LenW  = 17;

    typedef enum logic [2:0] {
        OP_TEXT   = 3'd0,
        OP_RANK   = 3'd1,
        OP_LCP    = 3'd2,
        OP_PAT    = 3'd3,
        OP_SRCH   = 3'd4,
        OP_SLICE  = 3'd5,
        OP_COUNT  = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    localparam logic CFG_TEXT_LEN  = 1'b0;
    localparam logic CFG_SUFFIX_TOT = 1'b1;
endpackage
`default_nettype wire

// ===== hw/rtl/suffix_array_pattern_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel   valid            stall            payload
// in        i_valid          o_stall          i_opcode i_index i_load_value i_pattern_start
//                                              i_pattern_length
// out       o_valid          i_stall          o_status o_first_rank o_last_rank o_match_count
// Loads are written when taken. A search starts from idle, then runs up to two binary
// searches of up to 17 probes each, with a setup step before each; a probe reads the
// rank, then for each compared byte steps through address, memory read, pattern capture
// and compare, or just compare when m is zero. A count walks the LCP memory entry by entry.
// One item at a time. Reset (synchronous, active low) clears control, configuration and the
// output register, not the memories. A finished result waits in place while the output
// register still holds an untaken word; the next item is taken as soon as the core is idle.
module suffix_array_pattern_search_core
    import sapsearch_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [16:0]       i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [2:0]        i_opcode,
    input  wire logic [15:0]       i_index,
    input  wire logic [15:0]       i_load_value,
    input  wire logic [15:0]       i_pattern_start,
    input  wire logic [8:0]        i_pattern_length,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_status,
    output logic [15:0]            o_first_rank,
    output logic [15:0]            o_last_rank,
    output logic [16:0]            o_match_count
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_INIT  = 11'b00000000010,
        S_RANK  = 11'b00000000100,
        S_RWAIT = 11'b00000001000,
        S_PAT   = 11'b00000010000,
        S_PWAIT = 11'b00000100000,
        S_TEXT  = 11'b00001000000,
        S_CMP   = 11'b00010000000,
        S_CNT   = 11'b00100000000,
        S_DONE  = 11'b01000000000,
        S_CWAIT = 11'b10000000000
    } t_state;

    logic [7:0]  m_text [0:65535];
    logic [15:0] m_rank [0:65535];
    logic [15:0] m_lcp  [0:65535];
    logic [7:0]  m_pat  [0:255];

    t_state      r_st;
    logic [16:0] r_tlen, r_stot;
    logic [16:0] r_n;
    logic        r_slice;
    logic [15:0] r_pbase;
    logic [8:0]  r_m;
    logic        r_upper;
    logic [16:0] r_l, r_h, r_mid;
    logic        r_final;
    logic [8:0]  r_i;
    logic [7:0]  r_pa;
    logic [15:0] r_first;
    logic [16:0] r_ci, r_cnt, r_bound;
    logic        r_ovalid;
    logic [1:0]  r_status;
    logic [1:0]  r_code;
    logic [15:0] r_ofirst, r_olast;
    logic [16:0] r_ocnt;

    logic [15:0] r_taddr, r_raddr, r_laddr;
    logic [7:0]  r_pidx;
    logic [7:0]  r_tq, r_pq;
    logic [15:0] r_rq, r_lq;

    logic        w_acc;
    logic [16:0] w_n;
    logic [16:0] w_diff;
    logic [16:0] w_midsel;
    logic [8:0]  w_mc;
    logic [17:0] w_pend;
    logic [17:0] w_sum;
    logic [1:0]  w_sign;
    logic [1:0]  w_cmp;
    logic        w_done;
    logic        w_oblk;
    logic        w_fire;

    assign w_acc  = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE);
    assign w_n    = (r_tlen > 17'd65536) ? 17'd65536 : r_tlen;
    assign w_mc   = (i_pattern_length > 9'd256) ? 9'd256 : i_pattern_length;
    assign w_pend = {2'b0, i_pattern_start} + {9'b0, w_mc};
    assign w_diff = r_h - r_l;
    assign w_midsel = (r_upper && w_diff == 17'd1) ? r_h : (r_l + {1'b0, w_diff[16:1]});
    assign w_sum  = {2'b0, r_rq} + {9'b0, r_m};
    assign w_sign = (r_pa == r_tq) ? 2'd0 : ((r_pa < r_tq) ? 2'd2 : 2'd1);
    assign w_cmp  = (r_m == 9'd0) ? 2'd0 : w_sign;
    assign w_done = (r_i + 9'd1 >= r_m);
    assign w_oblk = r_ovalid && i_stall;
    assign w_fire = !w_oblk && ((r_st == S_DONE) || (r_st == S_CNT && r_ci >= r_bound)
                    || (r_st == S_CMP && w_cmp == 2'd0 && (r_m == 9'd0 || w_done)
                        && r_final && r_upper));

    always_ff @(posedge i_clk) begin
        if (w_acc && i_opcode == OP_TEXT) begin
            m_text[i_index] <= i_load_value[7:0];
        end
        r_tq <= m_text[r_taddr];
    end
    always_ff @(posedge i_clk) begin
        if (w_acc && i_opcode == OP_RANK) begin
            m_rank[i_index] <= i_load_value;
        end
        r_rq <= m_rank[r_raddr];
    end
    always_ff @(posedge i_clk) begin
        if (w_acc && i_opcode == OP_LCP) begin
            m_lcp[i_index] <= i_load_value;
        end
        r_lq <= m_lcp[r_laddr];
    end
    always_ff @(posedge i_clk) begin
        if (w_acc && i_opcode == OP_PAT && i_index[15:8] == 8'd0) begin
            m_pat[i_index[7:0]] <= i_load_value[7:0];
        end
        r_pq <= m_pat[r_pidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_tlen   <= '0;
            r_stot   <= '0;
            r_ovalid <= 1'b0;
            r_status <= '0;
            r_ofirst <= '0;
            r_olast  <= '0;
            r_ocnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TEXT_LEN) r_tlen <= i_cfg_data;
                else r_stot <= i_cfg_data;
            end
            if (w_fire) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (w_acc) begin
                        r_m     <= (i_opcode == OP_COUNT) ? i_pattern_length : w_mc;
                        r_slice <= (i_opcode == OP_SLICE);
                        r_pbase <= i_pattern_start;
                        r_n     <= w_n;
                        r_upper <= 1'b0;
                        r_bound <= (r_stot > 17'd65536) ? 17'd65536 : r_stot;
                        r_ci    <= {1'b0, i_index} + 17'd1;
                        r_cnt   <= 17'd1;
                        if (i_opcode == OP_COUNT) begin
                            r_laddr <= i_index + 16'd1;
                            r_st    <= S_CNT;
                        end else if (i_opcode == OP_SRCH || i_opcode == OP_SLICE) begin
                            if (i_opcode == OP_SLICE && w_pend > {1'b0, w_n}) begin
                                r_code <= ST_SHORT;
                                r_st   <= S_DONE;
                            end else if (w_n == 17'd0) begin
                                r_code <= ST_MISS;
                                r_st   <= S_DONE;
                            end else begin
                                r_st <= S_INIT;
                            end
                        end
                    end
                end
                S_INIT: begin
                    r_l  <= '0;
                    r_h  <= r_n - 17'd1;
                    r_st <= S_RANK;
                end
                S_RANK: begin
                    r_final <= (r_l >= r_h);
                    r_mid   <= (r_l >= r_h) ? r_l : w_midsel;
                    r_raddr <= (r_l >= r_h) ? r_l[15:0] : w_midsel[15:0];
                    r_st    <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_i  <= '0;
                    r_st <= S_PAT;
                end
                S_PAT: begin
                    if (w_sum >= {1'b0, r_n}) begin
                        r_code <= ST_SHORT;
                        r_st   <= S_DONE;
                    end else if (r_m == 9'd0) begin
                        r_st <= S_CMP;
                    end else begin
                        r_pidx  <= r_i[7:0];
                        r_taddr <= r_pbase + {7'b0, r_i};
                        r_st    <= S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    r_taddr <= r_rq + {7'b0, r_i};
                    r_st    <= S_TEXT;
                end
                S_TEXT: begin
                    r_pa <= r_slice ? r_tq : r_pq;
                    r_st <= S_CMP;
                end
                S_CMP: begin
                    if (w_cmp == 2'd0 && r_m != 9'd0 && !w_done) begin
                        r_i  <= r_i + 9'd1;
                        r_st <= S_PAT;
                    end else if (r_final) begin
                        if (w_cmp != 2'd0) begin
                            r_code <= ST_MISS;
                            r_st   <= S_DONE;
                        end else if (!r_upper) begin
                            r_first <= r_l[15:0];
                            r_upper <= 1'b1;
                            r_st    <= S_INIT;
                        end else if (!w_oblk) begin
                            r_status <= ST_FOUND;
                            r_ofirst <= r_first;
                            r_olast  <= r_l[15:0];
                            r_ocnt   <= '0;
                            r_st     <= S_IDLE;
                        end
                    end else begin
                        if (!r_upper) begin
                            if (w_cmp != 2'd1) r_h <= r_mid;
                            else r_l <= r_mid + 17'd1;
                        end else begin
                            if (w_cmp != 2'd2) r_l <= r_mid;
                            else r_h <= r_mid - 17'd1;
                        end
                        r_st <= S_RANK;
                    end
                end
                S_CNT: begin
                    if (r_ci < r_bound) begin
                        r_st <= S_CWAIT;
                    end else if (!w_oblk) begin
                        r_status <= ST_FOUND;
                        r_ofirst <= '0;
                        r_olast  <= '0;
                        r_ocnt   <= r_cnt;
                        r_st     <= S_IDLE;
                    end
                end
                S_CWAIT: begin
                    if ({1'b0, r_lq} >= {8'b0, r_m}) begin
                        r_cnt   <= r_cnt + 17'd1;
                        r_ci    <= r_ci + 17'd1;
                        r_laddr <= r_laddr + 16'd1;
                    end else begin
                        r_ci <= r_bound;
                    end
                    r_st <= S_CNT;
                end
                S_DONE: begin
                    if (!w_oblk) begin
                        r_status <= r_code;
                        r_ofirst <= '0;
                        r_olast  <= '0;
                        r_ocnt   <= '0;
                        r_st     <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_status;
    assign o_first_rank  = r_ofirst;
    assign o_last_rank   = r_olast;
    assign o_match_count = r_ocnt;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != S_IDLE |-> !w_acc) else $error("accept while busy");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && i_stall |=> r_ovalid && $stable(o_status)) else $error("result lost");
    a_one_hot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("state");
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import sapsearch_pkg::*;

    localparam int DEPTH = 65536;
    localparam int PAT_DEPTH = 256;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] first_rank;
        logic [15:0] last_rank;
        logic [16:0] match_count;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [16:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_opcode;
    logic [15:0] i_index;
    logic [15:0] i_load_value;
    logic [15:0] i_pattern_start;
    logic [8:0]  i_pattern_length;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [15:0] o_first_rank;
    logic [15:0] o_last_rank;
    logic [16:0] o_match_count;

    suffix_array_pattern_search_core uut (.*);

    logic [7:0]  text_mem [DEPTH];
    logic [15:0] rank_mem [DEPTH];
    logic [15:0] lcp_mem [DEPTH];
    logic [7:0]  pat_mem [PAT_DEPTH];
    int          text_len_reg;
    int          suffix_tot_reg;
    t_answer     answers_q [$];
    int          errors;
    int          cycles;
    int          words_sent;
    int          answers_seen;
    int          burst_left;
    int          stall_mode;
    int          stall_span;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[suffix_array_pattern_search_core] ERROR");
            $finish;
        end
    end

    function automatic int clamp_depth(int v);
        return v > DEPTH ? DEPTH : v;
    endfunction

    function automatic int compare_at(int pos, int m, bit slice, int base);
        logic [7:0] a;
        logic [7:0] b;
        for (int i = 0; i < m; i++) begin
            a = slice ? text_mem[(base + i) % DEPTH] : pat_mem[i % PAT_DEPTH];
            b = text_mem[(pos + i) % DEPTH];
            if (a != b) return a < b ? -1 : 1;
        end
        return 0;
    endfunction

    function automatic logic [1:0] find_range(int m, int n, bit slice, int base,
                                              output int first, output int last);
        int lo;
        int hi;
        int mid;
        int pos;
        first = 0;
        last = 0;
        if (n == 0) return ST_MISS;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            pos = rank_mem[mid];
            if (pos + m >= n) return ST_SHORT;
            if (compare_at(pos, m, slice, base) <= 0) hi = mid;
            else lo = mid + 1;
        end
        pos = rank_mem[lo];
        if (pos + m >= n) return ST_SHORT;
        if (compare_at(pos, m, slice, base) != 0) return ST_MISS;
        first = lo;
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mid = (hi - lo == 1) ? hi : lo + (hi - lo) / 2;
            pos = rank_mem[mid];
            if (pos + m >= n) return ST_SHORT;
            if (compare_at(pos, m, slice, base) >= 0) lo = mid;
            else hi = mid - 1;
        end
        pos = rank_mem[lo];
        if (pos + m >= n) return ST_SHORT;
        if (compare_at(pos, m, slice, base) != 0) return ST_MISS;
        last = lo;
        return ST_FOUND;
    endfunction

    function automatic bit predict_word(t_op op, int idx, int val, int pstart, int len,
                                        output t_answer r);
        int n;
        int m;
        int first;
        int last;
        int bound;
        int cnt;
        r = '0;
        n = clamp_depth(text_len_reg);
        m = len;
        case (op)
            OP_TEXT: text_mem[idx] = val[7:0];
            OP_RANK: rank_mem[idx] = val[15:0];
            OP_LCP: lcp_mem[idx] = val[15:0];
            OP_PAT: if (idx < PAT_DEPTH) pat_mem[idx] = val[7:0];
            OP_SRCH, OP_SLICE: begin
                if (m > PAT_DEPTH) m = PAT_DEPTH;
                if (op == OP_SLICE && pstart + m > n) r.status = ST_SHORT;
                else r.status = find_range(m, n, op == OP_SLICE, pstart, first, last);
                if (r.status == ST_FOUND) begin
                    r.first_rank = first[15:0];
                    r.last_rank = last[15:0];
                end
                return 1;
            end
            OP_COUNT: begin
                bound = clamp_depth(suffix_tot_reg);
                cnt = 1;
                for (int i = idx + 1; i < bound; i++) begin
                    if (lcp_mem[i] >= len) cnt++;
                    else break;
                end
                r.match_count = cnt[16:0];
                return 1;
            end
            default: ;
        endcase
        return 0;
    endfunction

    task automatic send_word(t_op op, int idx, int val, int pstart, int len);
        int gap;
        t_answer r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_opcode <= op;
        i_index <= idx[15:0];
        i_load_value <= val[15:0];
        i_pattern_start <= pstart[15:0];
        i_pattern_length <= len[8:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        words_sent++;
        if (predict_word(op, idx, val, pstart, len, r)) answers_q.insert(answers_q.size(), r);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (answers_q.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[16:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TEXT_LEN) text_len_reg = val;
        else suffix_tot_reg = val;
    endtask

    function automatic bit suffix_less(int a, int b, int n);
        for (int i = 0; ; i++) begin
            if (a + i >= n) return 1;
            if (b + i >= n) return 0;
            if (text_mem[a + i] != text_mem[b + i]) return text_mem[a + i] < text_mem[b + i];
        end
    endfunction

    // Load a random text with its sorted suffixes, LCP values and a pattern copy.
    task automatic load_text(int n, int sigma);
        int order [$];
        int j;
        int k;
        int src;
        for (int i = 0; i < n; i++)
            send_word(OP_TEXT, i, (i == n - 1) ? 0 : 8'h61 + $urandom_range(0, sigma - 1),
                      0, 0);
        for (int i = 0; i < n; i++) begin
            j = 0;
            while (j < order.size() && suffix_less(order[j], i, n)) j++;
            order.insert(j, i);
        end
        for (int i = 0; i < n; i++) send_word(OP_RANK, i, order[i], 0, 0);
        send_word(OP_LCP, 0, 0, 0, 0);
        for (int i = 1; i < n; i++) begin
            k = 0;
            while (order[i] + k < n && order[i - 1] + k < n &&
                   text_mem[order[i] + k] == text_mem[order[i - 1] + k]) k++;
            send_word(OP_LCP, i, k, 0, 0);
        end
        send_word(OP_LCP, n, 0, 0, 0);
        src = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++)
            send_word(OP_PAT, i, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                      : text_mem[(src + i) % n], 0, 0);
    endtask

    // Query mix; reads stay inside the loaded region.
    task automatic random_queries(int n, int count);
        int sel;
        int m;
        int ps;
        int idx;
        int bound;
        for (int q = 0; q < count; q++) begin
            sel = $urandom_range(0, 19);
            bound = clamp_depth(suffix_tot_reg);
            if (sel < 7) begin
                ps = $urandom_range(0, n - 1);
                m = $urandom_range(1, n - ps);
                send_word(OP_SLICE, 0, 0, ps, m);
            end else if (sel < 12) begin
                send_word(OP_SRCH, 0, 0, 0, $urandom_range(0, 3) == 0 ?
                          $urandom_range(0, 511) : $urandom_range(0, n - 1));
            end else if (sel < 15) begin
                idx = ($urandom_range(0, 4) != 0) ? $urandom_range(0, n - 1) : 16'hFFFF;
                m = (bound > n + 1) ? $urandom_range(1, 511) : $urandom_range(0, 8);
                send_word(OP_COUNT, idx, 0, 0, $urandom_range(0, 2) == 0 ? m
                          : $urandom_range(bound > n + 1 ? 1 : 0, 3));
            end else if (sel == 15) begin
                send_word(OP_SLICE, 0, 0, $urandom_range(n, 65535), $urandom_range(1, 511));
            end else if (sel == 16) begin
                send_word(OP_TEXT, $urandom_range(0, 65535), $urandom_range(0, 65535), 0, 0);
            end else if (sel == 17) begin
                send_word(OP_RANK, $urandom_range(0, 3) == 0 ? $urandom_range(0, n - 1)
                          : $urandom_range(n + 1, 65535), $urandom_range(0, 65535), 0, 0);
            end else if (sel == 18) begin
                send_word(OP_LCP, $urandom_range(n + 300, 65535), $urandom_range(0, 65535),
                          0, 0);
            end else begin
                send_word(OP_PAT, $urandom_range(0, 511), $urandom_range(0, 65535), 0, 0);
            end
        end
    endtask

    task automatic test_directed();
        write_reg(CFG_TEXT_LEN, 0);
        write_reg(CFG_SUFFIX_TOT, 0);
        send_word(OP_SRCH, 0, 0, 0, 1);
        send_word(OP_SLICE, 0, 0, 0, 1);
        send_word(OP_COUNT, 0, 0, 0, 1);
        send_word(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'h1FF);
        drain();
        write_reg(CFG_TEXT_LEN, 12);
        write_reg(CFG_SUFFIX_TOT, 12);
        load_text(12, 2);
        send_word(OP_SRCH, 0, 0, 0, 0);
        send_word(OP_SRCH, 0, 0, 0, 300);
        send_word(OP_SLICE, 0, 0, 11, 2);
        send_word(OP_SLICE, 0, 0, 16'hFFFF, 9'h1FF);
        send_word(OP_SLICE, 0, 0, 3, 2);
        send_word(OP_COUNT, 16'hFFFF, 0, 0, 0);
        send_word(OP_COUNT, 0, 0, 0, 0);
        send_word(OP_COUNT, 2, 0, 0, 1);
        send_word(OP_PAT, 300, 16'hFFFF, 0, 0);
        send_word(OP_NONE, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_random_phases();
        int n;
        for (int ph = 0; ph < 4; ph++) begin
            n = (ph == 3) ? 16 : $urandom_range(4, 10);
            write_reg(CFG_TEXT_LEN, n);
            write_reg(CFG_SUFFIX_TOT, (ph == 2) ? 17'h1FFFF : $urandom_range(0, n + 1));
            load_text(n, $urandom_range(1, 3));
            random_queries(n, 15);
            drain();
        end
    endtask

    task automatic test_full_length();
        rank_mem[32767] = 16'hFFFF;
        send_word(OP_RANK, 32767, 16'hFFFF, 0, 0);
        send_word(OP_LCP, 65535, 0, 0, 0);
        drain();
        write_reg(CFG_TEXT_LEN, 65536);
        write_reg(CFG_SUFFIX_TOT, 65536);
        send_word(OP_SRCH, 0, 0, 0, 5);
        send_word(OP_SLICE, 0, 0, 65500, 100);
        send_word(OP_COUNT, 65534, 0, 0, 1);
        drain();
        write_reg(CFG_TEXT_LEN, 131071);
        write_reg(CFG_SUFFIX_TOT, 131071);
        send_word(OP_SRCH, 0, 0, 0, 256);
        send_word(OP_SLICE, 0, 0, 65535, 2);
        send_word(OP_COUNT, 65535, 0, 0, 9'h1FF);
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_mode <= 0;
            stall_span <= 0;
        end else begin
            if (stall_span == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_span <= $urandom_range(20, 200);
            end else begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 2) == 0);
                2: i_stall <= ($urandom_range(0, 7) != 0);
                default: i_stall <= ~i_stall;
            endcase
            if (o_valid && !i_stall) begin
                answers_seen++;
                if (answers_q.size() == 0) begin
                    $error("unexpected result status=%0d", o_status);
                    errors++;
                end else begin
                    t_answer want;
                    want = answers_q.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        errors++;
                    end
                    if (o_first_rank !== want.first_rank) begin
                        $error("first_rank: expected %0d, got %0d", want.first_rank,
                               o_first_rank);
                        errors++;
                    end
                    if (o_last_rank !== want.last_rank) begin
                        $error("last_rank: expected %0d, got %0d", want.last_rank,
                               o_last_rank);
                        errors++;
                    end
                    if (o_match_count !== want.match_count) begin
                        $error("match_count: expected %0d, got %0d", want.match_count,
                               o_match_count);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        words_sent = 0;
        answers_seen = 0;
        burst_left = 0;
        text_len_reg = 0;
        suffix_tot_reg = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_opcode = OP_NONE;
        i_index = '0;
        i_load_value = '0;
        i_pattern_start = '0;
        i_pattern_length = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        test_full_length();
        if (answers_q.size() != 0) begin
            $error("%0d results never arrived", answers_q.size());
            errors++;
        end
        $display("Sent %0d words, checked %0d results over several text and limit settings.",
                 words_sent, answers_seen);
        if (errors == 0) begin
            $display("[suffix_array_pattern_search_core] OK");
        end else begin
            $display("[suffix_array_pattern_search_core] ERROR");
        end
        $finish;
    end
endmodule
